[rtl/cils_pkg.sv]
// Package for the cab indicator lamp sequencer: state codes, lamp patterns and field widths.
package cils_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned DelayW = 16;
	localparam int unsigned LampW  = 9;
	localparam int unsigned StateW = 4;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 16;

	typedef enum logic [StateW-1:0] {
		ST_OFF       = 4'd0,
		ST_POWER_ON  = 4'd1,
		ST_FLASH     = 4'd2,
		ST_POWERED   = 4'd3,
		ST_UNLOCKED  = 4'd4,
		ST_BRK_CLOSE = 4'd5,
		ST_LOCKING   = 4'd6,
		ST_BRK_DELAY = 4'd7,
		ST_LOCKED    = 4'd8
	} seq_state_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_POWER_LAMP_DELAY = 3'd0,
		REG_POWER_FLASH      = 3'd1,
		REG_LOCKING          = 3'd2,
		REG_BRK_LAMP_DELAY   = 3'd3,
		REG_ALARM_BLINK      = 3'd4
	} cfg_reg_t;

	localparam logic [DelayW-1:0] PowerLampDelayRst = 16'd2000;
	localparam logic [DelayW-1:0] PowerFlashRst     = 16'd200;
	localparam logic [DelayW-1:0] LockingRst        = 16'd1000;
	localparam logic [DelayW-1:0] BrkLampDelayRst   = 16'd200;
	localparam logic [DelayW-1:0] AlarmBlinkRst     = 16'd200;

	localparam logic [LampW-1:0] LampsNone       = 9'b000000000;
	localparam logic [LampW-1:0] LampsAll        = 9'b111111111;
	localparam logic [LampW-1:0] LampsBreaker    = 9'b000000001;
	localparam logic [LampW-1:0] LampsPowerFlash = 9'b001000011;
	localparam logic [LampW-1:0] LampsPowered    = 9'b000000011;
	localparam logic [LampW-1:0] LampsBrkClosed  = 9'b000101011;
	localparam logic [LampW-1:0] LampsLocked     = 9'b000000010;

	localparam int unsigned BitLine     = 1;
	localparam int unsigned BitSeries   = 2;
	localparam int unsigned BitParallel = 4;
	localparam int unsigned BitAlarm    = 8;

	localparam logic [1:0] CouplingSeries   = 2'd0;
	localparam logic [1:0] CouplingParallel = 2'd1;

	typedef struct packed {
		logic       blink_request;
		logic [1:0] coupling_mode;
		logic       variator_active;
		logic       breaker_lock_request;
		logic       breaker_closed;
		logic       cab_unlocked;
		logic       main_switch_closed;
		logic [TimeW-1:0] now_ms;
	} eval_item_t;

	typedef struct packed {
		logic [1:0]        pad;
		logic [StateW-1:0] sequence_state;
		logic              blink_pending;
		logic [LampW-1:0]  lamp_mask;
	} lamp_result_t;

	// modular elapsed-time test: (now - start) mod 2^32 strictly above wait
	function automatic logic elapsed(input logic [TimeW-1:0] now, input logic [TimeW-1:0] start,
			input logic [DelayW-1:0] wait_ms);
		logic [TimeW-1:0] diff;
		diff = now - start;
		return diff > {{(TimeW-DelayW){1'b0}}, wait_ms};
	endfunction

endpackage

[rtl/cab_indicator_lamp_sequencer_unit.sv]
// Cab indicator lamp sequencer: input register, one-step state update, result register.
//
// Usage:
//   s_axis carries one evaluation per transfer: a millisecond time stamp plus the
//   switch, breaker, variator, coupling and blink request bits. For every input
//   transfer exactly one result leaves on m_axis: the 9-bit lamp mask, the pending
//   blink flag and the sequencer state code after that evaluation.
//   cfg_* writes the five 16-bit delay registers (index 0..4, others ignored); it is
//   always ready and should only be used while no evaluation is in flight.
// Path: an input transfer goes through the input register, then the sequencer step
//   into the result register, before it shows on m_axis.
// Throughput: one evaluation per cycle unless m_axis stalls. The step is a single
//   32-bit subtract and compare plus lamp selection, so state is updated back to back.
// Stall: when m_axis is held off, the result register holds, the staged input
//   waits, and s_tready drops only once both are full; no transfer is lost.
// Reset (arst_n low): sequencer in the off state, all lamps off, time marks and
//   blink latch cleared, delay registers back to their defaults, both stages empty.
module cab_indicator_lamp_sequencer_unit
	import cils_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// tdata: now_ms[31:0], main_switch_closed[32], cab_unlocked[33], breaker_closed[34],
	//        breaker_lock_request[35], variator_active[36], coupling_mode[38:37],
	//        blink_request[39]
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InDataW-1:0]   s_tdata,
	// tdata: lamp_mask[8:0], blink_pending[9], sequence_state[13:10], zero[15:14]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutDataW-1:0]  m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [DelayW-1:0]    cfg_data
);

	// delay registers
	logic [DelayW-1:0] power_lamp_delay_q, power_flash_q, locking_q, brk_lamp_delay_q;
	logic [DelayW-1:0] alarm_blink_q;

	// input stage
	logic       valid_s1;
	eval_item_t item_s1;
	logic       advance;

	// sequencer state
	seq_state_t       mode_q, mode_nx;
	logic [LampW-1:0] lamps_q, lamps_nx;
	logic [TimeW-1:0] phase_start_q, phase_start_nx;
	logic [TimeW-1:0] blink_start_q, blink_start_nx;
	logic             blink_q, blink_nx;

	// result register
	logic         out_valid_q;
	lamp_result_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_lamp_delay_q <= PowerLampDelayRst;
			power_flash_q      <= PowerFlashRst;
			locking_q          <= LockingRst;
			brk_lamp_delay_q   <= BrkLampDelayRst;
			alarm_blink_q      <= AlarmBlinkRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POWER_LAMP_DELAY: power_lamp_delay_q <= cfg_data;
				REG_POWER_FLASH:      power_flash_q      <= cfg_data;
				REG_LOCKING:          locking_q          <= cfg_data;
				REG_BRK_LAMP_DELAY:   brk_lamp_delay_q   <= cfg_data;
				REG_ALARM_BLINK:      alarm_blink_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// the staged item moves on whenever the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= eval_item_t'(s_tdata);
		end
	end

	// next state
	always_comb begin
		mode_nx = mode_q;
		case (mode_q)
			ST_OFF: begin
				if (item_s1.main_switch_closed) mode_nx = ST_POWER_ON;
			end
			ST_POWER_ON: begin
				if (!item_s1.main_switch_closed) mode_nx = ST_OFF;
				else if (elapsed(item_s1.now_ms, phase_start_q, power_lamp_delay_q))
					mode_nx = ST_FLASH;
			end
			ST_FLASH: begin
				if (!item_s1.main_switch_closed) mode_nx = ST_OFF;
				else if (elapsed(item_s1.now_ms, phase_start_q, power_flash_q))
					mode_nx = ST_POWERED;
			end
			ST_POWERED: begin
				if (!item_s1.main_switch_closed) mode_nx = ST_OFF;
				else if (item_s1.cab_unlocked) mode_nx = ST_UNLOCKED;
			end
			ST_UNLOCKED: begin
				if (!item_s1.main_switch_closed) mode_nx = ST_OFF;
				else if (!item_s1.cab_unlocked) mode_nx = ST_POWERED;
				else if (item_s1.breaker_closed) mode_nx = ST_BRK_CLOSE;
			end
			ST_BRK_CLOSE: begin
				if (!item_s1.main_switch_closed) mode_nx = ST_OFF;
				else if (!item_s1.breaker_closed) mode_nx = ST_UNLOCKED;
				else if (item_s1.breaker_lock_request) mode_nx = ST_LOCKING;
			end
			// the locking phases ignore the main switch
			ST_LOCKING: begin
				if (elapsed(item_s1.now_ms, phase_start_q, locking_q)) mode_nx = ST_BRK_DELAY;
			end
			ST_BRK_DELAY: begin
				if (elapsed(item_s1.now_ms, phase_start_q, brk_lamp_delay_q))
					mode_nx = ST_LOCKED;
			end
			ST_LOCKED: begin
				if (!item_s1.main_switch_closed) mode_nx = ST_OFF;
				else if (!item_s1.breaker_closed) mode_nx = ST_UNLOCKED;
			end
			default: mode_nx = ST_OFF;
		endcase
	end

	// lamps, time marks and blink latch
	always_comb begin
		lamps_nx       = lamps_q;
		phase_start_nx = phase_start_q;
		blink_start_nx = blink_start_q;
		blink_nx       = blink_q | item_s1.blink_request;
		case (mode_q)
			ST_OFF: begin
				if (item_s1.main_switch_closed) begin
					lamps_nx       = LampsBreaker;
					phase_start_nx = item_s1.now_ms;
				end
			end
			ST_POWER_ON: begin
				if (!item_s1.main_switch_closed) lamps_nx = LampsNone;
				else if (elapsed(item_s1.now_ms, phase_start_q, power_lamp_delay_q)) begin
					lamps_nx       = LampsPowerFlash;
					phase_start_nx = item_s1.now_ms;
				end
			end
			ST_FLASH: begin
				if (!item_s1.main_switch_closed) lamps_nx = LampsNone;
				else if (elapsed(item_s1.now_ms, phase_start_q, power_flash_q))
					lamps_nx = LampsPowered;
			end
			ST_POWERED: begin
				if (!item_s1.main_switch_closed) lamps_nx = LampsNone;
				else if (item_s1.cab_unlocked) lamps_nx = LampsAll;
			end
			ST_UNLOCKED: begin
				if (!item_s1.main_switch_closed) lamps_nx = LampsNone;
				else if (!item_s1.cab_unlocked) lamps_nx = LampsPowered;
				else if (item_s1.breaker_closed) lamps_nx = LampsBrkClosed;
			end
			ST_BRK_CLOSE: begin
				if (!item_s1.main_switch_closed) lamps_nx = LampsNone;
				else if (!item_s1.breaker_closed) lamps_nx = LampsAll;
				else if (item_s1.breaker_lock_request) phase_start_nx = item_s1.now_ms;
			end
			ST_LOCKING: begin
				if (elapsed(item_s1.now_ms, phase_start_q, locking_q)) begin
					lamps_nx       = LampsPowered;
					phase_start_nx = item_s1.now_ms;
				end
			end
			ST_BRK_DELAY: begin
				if (elapsed(item_s1.now_ms, phase_start_q, brk_lamp_delay_q))
					lamps_nx = LampsLocked;
			end
			ST_LOCKED: begin
				lamps_nx[BitLine]     = !item_s1.variator_active;
				lamps_nx[BitSeries]   = item_s1.variator_active &&
					(item_s1.coupling_mode == CouplingSeries);
				lamps_nx[BitParallel] = item_s1.variator_active &&
					(item_s1.coupling_mode == CouplingParallel);
				if (item_s1.variator_active) begin
					// a pending blink darkens a lit alarm lamp; it relights once the time is up
					if (blink_nx && lamps_q[BitAlarm]) begin
						lamps_nx[BitAlarm] = 1'b0;
						blink_start_nx     = item_s1.now_ms;
					end else if (elapsed(item_s1.now_ms, blink_start_q, alarm_blink_q)) begin
						lamps_nx[BitAlarm] = 1'b1;
						blink_nx           = 1'b0;
					end
				end else begin
					lamps_nx[BitAlarm] = 1'b0;
				end
				if (!item_s1.main_switch_closed) lamps_nx = LampsNone;
				else if (!item_s1.breaker_closed) lamps_nx = LampsAll;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= ST_OFF;
			lamps_q       <= LampsNone;
			phase_start_q <= '0;
			blink_start_q <= '0;
			blink_q       <= 1'b0;
		end else if (advance) begin
			mode_q        <= mode_nx;
			lamps_q       <= lamps_nx;
			phase_start_q <= phase_start_nx;
			blink_start_q <= blink_start_nx;
			blink_q       <= blink_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.pad            <= '0;
			result_q.sequence_state <= mode_nx;
			result_q.blink_pending  <= blink_nx;
			result_q.lamp_mask      <= lamps_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

`ifndef ASSERT_OFF
	// input side only backs up when both stages are full and the output is held off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("s_tready low without output stall");

	// in the off state every lamp is dark
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_OFF) |-> (lamps_q == LampsNone))
		else $error("lamps lit in off state");

	// while locked only line, series, parallel and alarm lamps may be lit
	a_locked_lamps: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ST_LOCKED) |-> ((lamps_q & 9'h0E9) == LampsNone))
		else $error("unexpected lamp in locked state");
`endif

endmodule

[verif/testbench.sv]
// Testbench for the cab indicator lamp sequencer: directed and random evaluations checked against a predictor.
module testbench
	import cils_pkg::*;
();

	// index past the last delay register; writes to it must change nothing
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [DelayW-1:0]   cfg_data;

	// predicted sequencer state, updated on every accepted evaluation
	seq_state_t        seq_mode     = ST_OFF;
	logic [LampW-1:0]  lamp_reg     = LampsNone;
	logic [TimeW-1:0]  phase_mark   = '0;
	logic [TimeW-1:0]  blink_mark   = '0;
	logic              blink_latched = 1'b0;
	logic [DelayW-1:0] delay_ms [5] = '{PowerLampDelayRst, PowerFlashRst, LockingRst,
		BrkLampDelayRst, AlarmBlinkRst};

	lamp_result_t   lamp_results_q [$];   // expected results, oldest first
	logic [8:0]     states_seen = '0;
	logic [TimeW-1:0] stim_now;            // running ms stamp of the random stimulus
	int unsigned    fail_count = 0;
	int unsigned    results_checked = 0;
	int unsigned    settings_used = 1;
	bit             sender_gaps = 1'b1;
	bit             sink_stalls = 1'b1;
	int unsigned    ready_hold = 0;

	cab_indicator_lamp_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#4_000_000;
		$display("[cab_indicator_lamp_sequencer_unit] ERROR");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// delay over once the wrapped difference is strictly above it
	function automatic logic ms_over(input logic [TimeW-1:0] stamp,
			input logic [TimeW-1:0] mark, input logic [DelayW-1:0] span);
		logic [TimeW-1:0] diff;
		diff = stamp - mark;
		return diff > {16'b0, span};
	endfunction

	// one sequencer step; queues the lamp result it yields
	function automatic void step_sequencer(input eval_item_t it);
		lamp_result_t res;
		logic         zba;
		logic         dj;
		logic         var_on;
		zba    = it.main_switch_closed;
		dj     = it.breaker_closed;
		var_on = it.variator_active;
		if (it.blink_request)
			blink_latched = 1'b1;
		case (seq_mode)
			ST_OFF: begin
				if (zba) begin
					lamp_reg = LampsBreaker;
					phase_mark = it.now_ms;
					seq_mode = ST_POWER_ON;
				end
			end
			ST_POWER_ON: begin
				if (!zba) begin
					lamp_reg = LampsNone;
					seq_mode = ST_OFF;
				end else if (ms_over(it.now_ms, phase_mark, delay_ms[REG_POWER_LAMP_DELAY])) begin
					lamp_reg = LampsPowerFlash;
					phase_mark = it.now_ms;
					seq_mode = ST_FLASH;
				end
			end
			ST_FLASH: begin
				if (!zba) begin
					lamp_reg = LampsNone;
					seq_mode = ST_OFF;
				end else if (ms_over(it.now_ms, phase_mark, delay_ms[REG_POWER_FLASH])) begin
					lamp_reg = LampsPowered;
					seq_mode = ST_POWERED;
				end
			end
			ST_POWERED: begin
				if (!zba) begin
					lamp_reg = LampsNone;
					seq_mode = ST_OFF;
				end else if (it.cab_unlocked) begin
					lamp_reg = LampsAll;
					seq_mode = ST_UNLOCKED;
				end
			end
			ST_UNLOCKED: begin
				if (!zba) begin
					lamp_reg = LampsNone;
					seq_mode = ST_OFF;
				end else if (!it.cab_unlocked) begin
					lamp_reg = LampsPowered;
					seq_mode = ST_POWERED;
				end else if (dj) begin
					lamp_reg = LampsBrkClosed;
					seq_mode = ST_BRK_CLOSE;
				end
			end
			ST_BRK_CLOSE: begin
				if (!zba) begin
					lamp_reg = LampsNone;
					seq_mode = ST_OFF;
				end else if (!dj) begin
					lamp_reg = LampsAll;
					seq_mode = ST_UNLOCKED;
				end else if (it.breaker_lock_request) begin
					phase_mark = it.now_ms;
					seq_mode = ST_LOCKING;
				end
			end
			// both locking phases ignore the main switch
			ST_LOCKING: begin
				if (ms_over(it.now_ms, phase_mark, delay_ms[REG_LOCKING])) begin
					lamp_reg = LampsPowered;
					phase_mark = it.now_ms;
					seq_mode = ST_BRK_DELAY;
				end
			end
			ST_BRK_DELAY: begin
				if (ms_over(it.now_ms, phase_mark, delay_ms[REG_BRK_LAMP_DELAY])) begin
					lamp_reg = LampsLocked;
					seq_mode = ST_LOCKED;
				end
			end
			ST_LOCKED: begin
				lamp_reg[BitLine]     = !var_on;
				lamp_reg[BitSeries]   = var_on && (it.coupling_mode == CouplingSeries);
				lamp_reg[BitParallel] = var_on && (it.coupling_mode == CouplingParallel);
				if (var_on) begin
					// a request only starts a blink while the alarm lamp is lit
					if (blink_latched && lamp_reg[BitAlarm]) begin
						lamp_reg[BitAlarm] = 1'b0;
						blink_mark = it.now_ms;
					end else if (ms_over(it.now_ms, blink_mark, delay_ms[REG_ALARM_BLINK])) begin
						lamp_reg[BitAlarm] = 1'b1;
						blink_latched = 1'b0;
					end
				end else begin
					lamp_reg[BitAlarm] = 1'b0;   // latch kept while variator idle
				end
				if (!zba) begin
					lamp_reg = LampsNone;
					seq_mode = ST_OFF;
				end else if (!dj) begin
					lamp_reg = LampsAll;
					seq_mode = ST_UNLOCKED;
				end
			end
			default: seq_mode = ST_OFF;
		endcase
		states_seen[seq_mode] = 1'b1;
		res.pad            = '0;
		res.sequence_state = seq_mode;
		res.blink_pending  = blink_latched;
		res.lamp_mask      = lamp_reg;
		lamp_results_q.push_back(res);
	endfunction

	function automatic eval_item_t eval_at(input logic [TimeW-1:0] stamp,
			input int unsigned zba, input int unsigned unl, input int unsigned dj,
			input int unsigned lock, input int unsigned var_on, input logic [1:0] cpl,
			input int unsigned blink);
		eval_item_t it;
		it.now_ms               = stamp;
		it.main_switch_closed   = zba[0];
		it.cab_unlocked         = unl[0];
		it.breaker_closed       = dj[0];
		it.breaker_lock_request = lock[0];
		it.variator_active      = var_on[0];
		it.coupling_mode        = cpl;
		it.blink_request        = blink[0];
		return it;
	endfunction

	// stamp step around the delay that matters: on it, just past it, or anywhere
	function automatic logic [TimeW-1:0] time_advance(input logic [DelayW-1:0] span);
		case ($urandom_range(0, 11))
			0: return '0;
			1: return {16'b0, span};
			2: return {16'b0, span} + 32'd1;
			3: return $urandom;
			default: return $urandom_range(0, span / 2 + 1);
		endcase
	endfunction

	// mostly a plausible cab sequence steered by the predicted state, some pure noise
	function automatic eval_item_t next_stimulus(input int unsigned noise_pct);
		eval_item_t        it;
		logic [39:0]       raw;
		logic [DelayW-1:0] span;
		if ($urandom_range(0, 99) < noise_pct) begin
			raw[31:0]  = $urandom;
			raw[39:32] = 8'($urandom_range(0, 255));
			it = raw;
			stim_now = it.now_ms;
			return it;
		end
		it.main_switch_closed   = $urandom_range(0, 39) != 0;
		it.cab_unlocked         = (seq_mode >= ST_POWERED) ^ ($urandom_range(0, 29) == 0);
		it.breaker_closed       = (seq_mode >= ST_UNLOCKED) ^ ($urandom_range(0, 29) == 0);
		it.breaker_lock_request = (seq_mode == ST_BRK_CLOSE) ? ($urandom_range(0, 2) == 0)
			: ($urandom_range(0, 1) == 1);
		it.variator_active      = $urandom_range(0, 3) != 0;
		it.coupling_mode        = 2'($urandom_range(0, 3));
		it.blink_request        = $urandom_range(0, 5) == 0;
		case (seq_mode)
			ST_POWER_ON: span = delay_ms[REG_POWER_LAMP_DELAY];
			ST_FLASH:    span = delay_ms[REG_POWER_FLASH];
			ST_LOCKING: begin
				span = delay_ms[REG_LOCKING];
				it.main_switch_closed = ($urandom_range(0, 1) == 1);
			end
			ST_BRK_DELAY: begin
				span = delay_ms[REG_BRK_LAMP_DELAY];
				it.main_switch_closed = ($urandom_range(0, 1) == 1);
			end
			ST_LOCKED:   span = delay_ms[REG_ALARM_BLINK];
			default:     span = DelayW'($urandom_range(0, 50));
		endcase
		stim_now = stim_now + time_advance(span);
		it.now_ms = stim_now;
		return it;
	endfunction

	// one evaluation transfer; prediction on acceptance, then an optional gap
	task automatic send_eval(input eval_item_t item);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		do @(posedge clk); while (!s_tready);
		step_sequencer(item);
		gap = sender_gaps ? idle_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait out every expected result plus the pipeline depth
	task automatic settle_outputs();
		s_tvalid <= 1'b0;
		while (lamp_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no toggle
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_ALARM_BLINK)
			delay_ms[idx] = val;
	endtask

	task automatic load_delays(input logic [DelayW-1:0] d_power, input logic [DelayW-1:0] d_flash,
			input logic [DelayW-1:0] d_lock, input logic [DelayW-1:0] d_brk,
			input logic [DelayW-1:0] d_blink);
		settle_outputs();
		write_reg(REG_POWER_LAMP_DELAY, d_power);
		write_reg(REG_POWER_FLASH, d_flash);
		write_reg(REG_LOCKING, d_lock);
		write_reg(REG_BRK_LAMP_DELAY, d_brk);
		write_reg(REG_ALARM_BLINK, d_blink);
		write_reg(REG_UNUSED, DelayW'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// random run; halfway the sender holds off until all results are back
	task automatic run_session(input int unsigned n_items, input logic [TimeW-1:0] first_stamp);
		stim_now = first_stamp;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i == n_items / 2)
				settle_outputs();
			send_eval(next_stimulus(5));
		end
	endtask

	// reset delays: power-on phases on their exact boundaries across the ms wrap, then locking
	task automatic test_power_up_timing();
		logic [TimeW-1:0] t0;
		logic [TimeW-1:0] t1;
		logic [TimeW-1:0] t2;
		t0 = 32'hFFFF_FC00;
		send_eval(eval_at(t0, 0, 0, 0, 0, 0, CouplingSeries, 0));
		send_eval(eval_at(t0, 1, 0, 0, 0, 0, CouplingSeries, 1));   // blink latched while off
		send_eval(eval_at(t0 + delay_ms[REG_POWER_LAMP_DELAY], 1, 0, 0, 0, 0, 2'd0, 0));
		t1 = t0 + delay_ms[REG_POWER_LAMP_DELAY] + 32'd1;           // past zero
		send_eval(eval_at(t1, 1, 0, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t1 + delay_ms[REG_POWER_FLASH], 1, 0, 0, 0, 0, 2'd0, 0));
		t2 = t1 + delay_ms[REG_POWER_FLASH] + 32'd1;
		send_eval(eval_at(t2, 1, 0, 0, 0, 0, 2'd0, 0));
		// unlock / relock and breaker close / open bounce
		send_eval(eval_at(t2, 1, 1, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t2, 1, 0, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t2, 1, 1, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t2, 1, 1, 1, 0, 0, 2'd0, 0));
		send_eval(eval_at(t2, 1, 1, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t2, 1, 1, 1, 0, 0, 2'd0, 0));
		send_eval(eval_at(t2, 1, 1, 1, 1, 0, 2'd0, 0));
		// main switch open in the locking phases must be ignored
		send_eval(eval_at(t2 + delay_ms[REG_LOCKING], 0, 0, 0, 0, 0, 2'd0, 0));
		t1 = t2 + delay_ms[REG_LOCKING] + 32'd1;
		send_eval(eval_at(t1, 0, 0, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t1 + delay_ms[REG_BRK_LAMP_DELAY], 0, 0, 0, 0, 0, 2'd0, 0));
		send_eval(eval_at(t1 + delay_ms[REG_BRK_LAMP_DELAY] + 32'd1, 0, 0, 0, 0, 0, 2'd0, 0));
	endtask

	// locked state: coupling lamps, alarm blink corner cases, exits, field extremes
	task automatic test_locked_lamps();
		logic [TimeW-1:0] t0;
		t0 = 32'h8000_0000;
		send_eval(eval_at(t0, 1, 1, 1, 0, 0, CouplingSeries, 0));      // variator idle
		// request while dark with the old blink long over: relit, request dropped
		send_eval(eval_at(t0 + 32'd1, 1, 1, 1, 0, 1, CouplingSeries, 1));
		send_eval(eval_at(t0 + 32'd2, 1, 1, 1, 0, 1, CouplingParallel, 1));
		send_eval(eval_at(t0 + 32'd2 + delay_ms[REG_ALARM_BLINK], 1, 1, 1, 0, 1, 2'd2, 0));
		send_eval(eval_at(t0 + 32'd10, 1, 1, 1, 0, 0, 2'd3, 0));      // idle mid-blink
		send_eval(eval_at(t0 + 32'd3 + delay_ms[REG_ALARM_BLINK], 1, 1, 1, 0, 1, 2'd3, 0));
		send_eval(eval_at(t0 + 32'd4000, 1, 1, 0, 0, 1, CouplingSeries, 0));  // breaker open
		send_eval(eval_at(t0 + 32'd4001, 0, 1, 0, 0, 1, CouplingSeries, 0));
		send_eval(eval_at(32'hFFFF_FFFF, 1, 1, 1, 1, 1, 2'd3, 1));
		send_eval(eval_at(32'h0000_0000, 0, 0, 0, 0, 0, CouplingSeries, 0));
	endtask

	// random cab sequences under several delay settings, extremes included
	task automatic test_delay_settings();
		// shortest delays: every timed phase ends on the first later stamp
		load_delays('0, '0, '0, '0, '0);
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		run_session(80, 32'd100);
		// longest delays starting just below the wrap, no idling either side
		load_delays(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		run_session(80, 32'hFFFF_0000);
		load_delays(DelayW'($urandom_range(1, 8)), DelayW'($urandom_range(1, 8)),
			DelayW'($urandom_range(1, 8)), DelayW'($urandom_range(1, 8)),
			DelayW'($urandom_range(1, 8)));
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		run_session(80, $urandom);
		load_delays(DelayW'($urandom), DelayW'($urandom), DelayW'($urandom),
			DelayW'($urandom), DelayW'($urandom));
		sender_gaps = 1'b1;
		sink_stalls = 1'b0;
		run_session(80, $urandom);
		load_delays(PowerLampDelayRst, PowerFlashRst, LockingRst, BrkLampDelayRst,
			AlarmBlinkRst);
		sender_gaps = 1'b0;
		sink_stalls = 1'b1;
		run_session(80, $urandom);
	endtask

	// result side back-pressure: random ready level held for a random stretch
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (ready_hold != 0) begin
				ready_hold--;
			end else if (sink_stalls) begin
				m_tready <= ($urandom_range(0, 99) < 65);
				ready_hold = idle_len();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// every result transfer against the oldest expectation
	always @(posedge clk) begin : result_check
		lamp_result_t got;
		lamp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = lamp_result_t'(m_tdata);
			if (lamp_results_q.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, got %h", $time,
					m_tdata);
				fail_count++;
			end else begin
				want = lamp_results_q.pop_front();
				compare_field("lamp_mask", 32'(want.lamp_mask), 32'(got.lamp_mask));
				compare_field("blink_pending", 32'(want.blink_pending),
					32'(got.blink_pending));
				compare_field("sequence_state", 32'(want.sequence_state),
					32'(got.sequence_state));
				compare_field("pad", 32'(want.pad), 32'(got.pad));
				results_checked++;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_timing();
		test_locked_lamps();
		test_delay_settings();
		settle_outputs();

		$display("Covered %0d evaluations under %0d delay settings, incl. ms counter wrap",
			results_checked, settings_used);
		$display("Sequencer states reached (bit n = state n): %b", states_seen);
		if (fail_count == 0 && lamp_results_q.size() == 0)
			$display("[cab_indicator_lamp_sequencer_unit] OK");
		else
			$display("[cab_indicator_lamp_sequencer_unit] ERROR");
		$finish;
	end

endmodule
